// ===== rtl/core/ghf_pkg.sv =====
// shared types, codes and defaults of the height grid hole filler
package ghf_pkg;

    // default sizes
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int IO_H_W    = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    // which neighbours take part in a cell update
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } nb_mask_t;

    // one result item
    typedef struct packed {
        logic              kind;
        logic [IO_H_W-1:0] height;
        logic              valid;
        logic              any;
    } out_item_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_SWEEP,
        ST_CHECK,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/ghf_cell.sv =====
// one chain cell: holds the left-column and right-column entries of one row slot
module ghf_cell #(
    parameter int EW = 18
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic [EW-1:0] l_in,
    input  logic [EW-1:0] r_in,
    output logic [EW-1:0] l_q,
    output logic [EW-1:0] r_q
);

    logic [EW-1:0] l_reg;
    logic [EW-1:0] r_reg;

    // take the neighbour's entries on every shift
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            l_reg <= l_in;
            r_reg <= r_in;
        end
    end

    assign l_q = l_reg;
    assign r_q = r_reg;

endmodule

// ===== rtl/core/ghf_chain.sv =====
// row of cells carrying the finished previous column and the old current column
module ghf_chain #(
    parameter int MAX_ROWS = 64,
    parameter int EW       = 18
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic [EW-1:0] l_in,
    input  logic [EW-1:0] r_in,
    output logic [EW-1:0] l_head,
    output logic [EW-1:0] r_head,
    output logic [EW-1:0] r_next
);

    logic [EW-1:0] l_tap [MAX_ROWS+1];
    logic [EW-1:0] r_tap [MAX_ROWS+1];

    assign l_tap[MAX_ROWS] = l_in;
    assign r_tap[MAX_ROWS] = r_in;

    // cell i takes from cell i+1, the tail from the inputs
    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
        ghf_cell #(
            .EW(EW)
        ) u_cell (
            .aclk    (aclk),
            .shift_en(shift_en),
            .l_in    (l_tap[i+1]),
            .r_in    (r_tap[i+1]),
            .l_q     (l_tap[i]),
            .r_q     (r_tap[i])
        );
    end

    assign l_head = l_tap[0];
    assign r_head = r_tap[0];
    assign r_next = r_tap[1];

endmodule

// ===== rtl/core/ghf_min_unit.sv =====
// minimum-of-neighbours update of one hole cell
module ghf_min_unit #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic [HEIGHT_BITS:0] cur,
    input  logic [HEIGHT_BITS:0] left,
    input  logic [HEIGHT_BITS:0] right,
    input  logic [HEIGHT_BITS:0] top,
    input  logic [HEIGHT_BITS:0] bottom,
    input  ghf_pkg::nb_mask_t    mask,
    output logic [HEIGHT_BITS:0] upd,
    output logic                 changed
);
    import ghf_pkg::*;

    logic [HEIGHT_BITS:0]          nb [4];
    logic [3:0]                    use_nb;
    logic                          v;
    logic signed [HEIGHT_BITS-1:0] h;

    assign nb[0]  = left;
    assign nb[1]  = right;
    assign nb[2]  = top;
    assign nb[3]  = bottom;
    assign use_nb = {mask.bottom, mask.top, mask.right, mask.left};

    // neighbours in order left, right, top, bottom; ties are no change
    always_comb begin
        v       = cur[HEIGHT_BITS];
        h       = signed'(cur[HEIGHT_BITS-1:0]);
        changed = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (use_nb[i] && nb[i][HEIGHT_BITS] &&
                (!v || signed'(nb[i][HEIGHT_BITS-1:0]) < h)) begin
                h       = signed'(nb[i][HEIGHT_BITS-1:0]);
                v       = 1'b1;
                changed = 1'b1;
            end
        end
        upd = {v, h};
    end

endmodule

// ===== rtl/core/grid_hole_fill_min_neighbour.sv =====
// top level of the height grid hole filler: command decode, cell store, sweep control
//
// Usage:
//   Input channel s_*: one item per handshake. Command load writes one cell
//   (height and known flag), read returns one cell, fill runs sweeps until
//   nothing changes and then answers with a fill-finished item.
//   Result channel m_*: read answers and fill-finished items, in order.
//   Config channel cfg_*: always ready; index 0 sets rows in use, 1 columns.
//   Loads and reads stream one per cycle while s_ready is high; a read answer
//   passes the store's read register and then the output queue. A fill first
//   sets valid flags from known flags, then runs sweeps, paced by the single
//   read port of the cell store feeding the cell chain one row per cycle, and
//   ends by posting its result.
//   After reset the block clears every entry of the cell store and accepts
//   no item meanwhile; config writes are taken.
//   A two-entry output queue holds results while the receiver stalls; the
//   input side stops accepting when the queue and in-flight reads fill it.
module grid_hole_fill_min_neighbour #(
    parameter int MAX_ROWS    = ghf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = ghf_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = ghf_pkg::DEF_HEIGHT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ghf_pkg::CMD_W-1:0]           s_command,
    input  logic [ghf_pkg::IDX_W-1:0]           s_row,
    input  logic [ghf_pkg::IDX_W-1:0]           s_col,
    input  logic signed [ghf_pkg::IO_H_W-1:0]   s_height,
    input  logic                                s_height_known,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kind,
    output logic signed [ghf_pkg::IO_H_W-1:0]   m_result_height,
    output logic                                m_result_valid,
    output logic                                m_any_known,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ghf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ghf_pkg::CFG_W-1:0]           cfg_data
);
    import ghf_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int AW    = ROW_W + COL_W;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = HEIGHT_BITS + 2;
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam logic signed [32:0] H_HI = 33'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [32:0] H_LO = -H_HI - 33'sd1;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [10:0]      rows_ext, cols_ext;
    logic [NR_W-1:0]  nr_sat, nr_reg;
    logic [NC_W-1:0]  nc_sat, nc_reg;

    // input decode
    logic                   in_acc, in_store;
    logic [AW-1:0]          in_addr;
    logic signed [32:0]     hin_ext, h_clamp;

    // cell store
    logic [EW-1:0]          mem [DEPTH];
    logic [EW-1:0]          rd_data_reg;
    logic [AW-1:0]          ra, wa;
    logic [EW-1:0]          wd;
    logic                   we;

    // sequencing
    logic [AW-1:0]          addr_cnt_reg;
    logic [ROW_W-1:0]       sw_row_reg;
    logic [NC_W-1:0]        sw_pass_reg;
    logic                   sw_last, sweep_start;
    logic                   s1_sw_reg, s1_copy_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [NC_W-1:0]        s1_pass_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic                   sweep_changed_reg, seen_known_reg;

    // sweep datapath
    logic [EW-1:0]          l_head, r_head, r_next, l_in, top_reg;
    logic                   row_used, proc, cur_known, upd_changed;
    logic [NC_W-1:0]        proc_col;
    nb_mask_t               nb_mask;
    logic [HEIGHT_BITS:0]   upd;

    // read answers and output queue
    logic                   rd_pend_reg, pend_instore_reg, rd_v;
    logic signed [32:0]     hout_ext;
    out_item_t              fifo_q [2];
    logic                   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]             count_reg;
    logic                   push, pop, push_fill;
    out_item_t              push_item, head_item;
    logic [2:0]             occ;

    // config registers, saturated at fill start
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_W'(64);
            cols_cfg_reg <= CFG_W'(64);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS: rows_cfg_reg <= cfg_data;
                REG_COLS: cols_cfg_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign rows_ext = 11'(rows_cfg_reg);
    assign cols_ext = 11'(cols_cfg_reg);
    assign nr_sat = (rows_ext == 11'd0) ? NR_W'(1) :
                    (rows_ext > 11'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : NR_W'(rows_ext);
    assign nc_sat = (cols_ext == 11'd0) ? NC_W'(1) :
                    (cols_ext > 11'(MAX_COLS)) ? NC_W'(MAX_COLS) : NC_W'(cols_ext);

    // input decode
    assign in_acc   = s_valid && s_ready;
    assign in_store = (11'(s_row) < 11'(MAX_ROWS)) && (11'(s_col) < 11'(MAX_COLS));
    assign in_addr  = {ROW_W'(s_row), COL_W'(s_col)};
    assign hin_ext  = 33'(s_height);
    assign h_clamp  = (hin_ext > H_HI) ? H_HI : ((hin_ext < H_LO) ? H_LO : hin_ext);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (addr_cnt_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc && s_command == CMD_FILL) state_next = ST_COPY;
            end
            ST_COPY: begin
                if (addr_cnt_reg == '1) state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (sw_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = (sweep_changed_reg && seen_known_reg) ? ST_SWEEP : ST_DONE;
            end
            ST_DONE: begin
                if (count_reg != 2'd2) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign sw_last = (sw_row_reg == ROW_W'(MAX_ROWS - 1)) && (sw_pass_reg == nc_reg);
    assign sweep_start = (state_reg == ST_COPY && addr_cnt_reg == '1) ||
                         (state_reg == ST_DECIDE && sweep_changed_reg && seen_known_reg);

    // counters and stage-one flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_cnt_reg      <= '0;
            sw_row_reg        <= '0;
            sw_pass_reg       <= '0;
            s1_sw_reg         <= 1'b0;
            s1_copy_reg       <= 1'b0;
            sweep_changed_reg <= 1'b0;
            seen_known_reg    <= 1'b0;
            nr_reg            <= NR_W'(MAX_ROWS);
            nc_reg            <= NC_W'(MAX_COLS);
        end else begin
            s1_sw_reg   <= (state_reg == ST_SWEEP);
            s1_copy_reg <= (state_reg == ST_COPY);
            if (state_reg == ST_CLEAR || state_reg == ST_COPY) begin
                addr_cnt_reg <= addr_cnt_reg + AW'(1);
            end else if (state_reg == ST_IDLE && in_acc && s_command == CMD_FILL) begin
                addr_cnt_reg <= '0;
                nr_reg       <= nr_sat;
                nc_reg       <= nc_sat;
            end
            if (sweep_start) begin
                sw_row_reg        <= '0;
                sw_pass_reg       <= '0;
                sweep_changed_reg <= 1'b0;
                seen_known_reg    <= 1'b0;
            end else begin
                if (state_reg == ST_SWEEP) begin
                    if (sw_row_reg == ROW_W'(MAX_ROWS - 1)) begin
                        sw_row_reg  <= '0;
                        sw_pass_reg <= sw_pass_reg + NC_W'(1);
                    end else begin
                        sw_row_reg <= sw_row_reg + ROW_W'(1);
                    end
                end
                if (proc && cur_known) seen_known_reg <= 1'b1;
                if (proc && !cur_known && upd_changed) sweep_changed_reg <= 1'b1;
            end
        end
    end

    // payload of stage one
    always_ff @(posedge aclk) begin
        s1_row_reg  <= sw_row_reg;
        s1_pass_reg <= sw_pass_reg;
        s1_addr_reg <= addr_cnt_reg;
        if (s1_sw_reg) top_reg <= l_in;
    end

    // cell update at stage one
    assign row_used  = NR_W'(s1_row_reg) < nr_reg;
    assign proc      = s1_sw_reg && (s1_pass_reg != '0) && row_used;
    assign cur_known = r_head[EW-1];
    assign proc_col  = s1_pass_reg - NC_W'(1);
    assign nb_mask.left   = s1_pass_reg > NC_W'(1);
    assign nb_mask.right  = s1_pass_reg < nc_reg;
    assign nb_mask.top    = s1_row_reg != '0;
    assign nb_mask.bottom = (NR_W'(s1_row_reg) + NR_W'(1)) < nr_reg;

    ghf_min_unit #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_min (
        .cur    (r_head[HEIGHT_BITS:0]),
        .left   (l_head[HEIGHT_BITS:0]),
        .right  (rd_data_reg[HEIGHT_BITS:0]),
        .top    (top_reg[HEIGHT_BITS:0]),
        .bottom (r_next[HEIGHT_BITS:0]),
        .mask   (nb_mask),
        .upd    (upd),
        .changed(upd_changed)
    );

    assign l_in = !proc ? '0 : (cur_known ? r_head : {1'b0, upd});

    ghf_chain #(
        .MAX_ROWS(MAX_ROWS),
        .EW      (EW)
    ) u_chain (
        .aclk    (aclk),
        .shift_en(s1_sw_reg),
        .l_in    (l_in),
        .r_in    (rd_data_reg),
        .l_head  (l_head),
        .r_head  (r_head),
        .r_next  (r_next)
    );

    // read port address
    always_comb begin
        case (state_reg)
            ST_IDLE: ra = in_addr;
            ST_COPY: ra = addr_cnt_reg;
            default: ra = {sw_row_reg, sw_pass_reg[COL_W-1:0]};
        endcase
    end

    // write port select
    always_comb begin
        we = 1'b0;
        wa = in_addr;
        wd = {s_height_known, s_height_known, h_clamp[HEIGHT_BITS-1:0]};
        if (state_reg == ST_CLEAR) begin
            we = 1'b1;
            wa = addr_cnt_reg;
            wd = '0;
        end else if (in_acc && s_command == CMD_LOAD && in_store) begin
            we = 1'b1;
        end else if (s1_copy_reg) begin
            we = 1'b1;
            wa = s1_addr_reg;
            wd = {rd_data_reg[EW-1], rd_data_reg[EW-1], rd_data_reg[HEIGHT_BITS-1:0]};
        end else if (proc && !cur_known) begin
            we = 1'b1;
            wa = {s1_row_reg, proc_col[COL_W-1:0]};
            wd = {1'b0, upd};
        end
    end

    // cell store
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    // read answer tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= in_acc && s_command == CMD_READ;
        end
    end

    always_ff @(posedge aclk) begin
        pend_instore_reg <= in_store;
    end

    assign rd_v     = pend_instore_reg && rd_data_reg[HEIGHT_BITS];
    assign hout_ext = 33'(signed'(rd_data_reg[HEIGHT_BITS-1:0]));

    // output queue
    assign push_fill = (state_reg == ST_DONE) && (count_reg != 2'd2);
    assign push      = rd_pend_reg || push_fill;
    assign pop       = m_valid && m_ready;

    always_comb begin
        if (rd_pend_reg) begin
            push_item.kind   = KIND_READ;
            push_item.height = rd_v ? hout_ext[IO_H_W-1:0] : '0;
            push_item.valid  = rd_v;
            push_item.any    = 1'b0;
        end else begin
            push_item.kind   = KIND_FILL;
            push_item.height = '0;
            push_item.valid  = 1'b0;
            push_item.any    = seen_known_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_q[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign head_item       = fifo_q[rd_ptr_reg];
    assign m_valid         = count_reg != 2'd0;
    assign m_kind          = head_item.kind;
    assign m_result_height = signed'(head_item.height);
    assign m_result_valid  = head_item.valid;
    assign m_any_known     = head_item.any;

    // input credit against queue space
    assign occ     = {1'b0, count_reg} + {2'b0, rd_pend_reg} - {2'b0, pop};
    assign s_ready = (state_reg == ST_IDLE) && (occ < 3'd2);

`ifndef SYNTHESIS
    // a fill item starts the valid-flag pass
    a_fill_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_FILL) |=> state_reg == ST_COPY)
        else $error("fill did not start valid pass");

    // queue plus in-flight reads never exceed its depth
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} + {2'b0, rd_pend_reg}) <= 3'd2)
        else $error("output queue overrun");

    // no read answer in flight when a fill posts its result
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !rd_pend_reg)
        else $error("read answer collides with fill result");
`endif

endmodule

// ===== bench/tb.sv =====
// testbench for the height grid hole filler: directed table, then random phases
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ghf_pkg::*;

    localparam int NROW = 64;
    localparam int NCOL = 64;
    localparam int CELLS = NROW * NCOL;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam int TAIL_CYCLES = 20;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_command = CMD_LOAD;
    logic [IDX_W-1:0] s_row = '0;
    logic [IDX_W-1:0] s_col = '0;
    logic signed [IO_H_W-1:0] s_height = '0;
    logic s_height_known = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic signed [IO_H_W-1:0] m_result_height;
    logic m_result_valid;
    logic m_any_known;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
    logic [CFG_W-1:0] cfg_data = '0;

    grid_hole_fill_min_neighbour i_dut (.*);

    always #2 aclk = ~aclk;

    // grid mirror kept alongside the block
    logic signed [IO_H_W-1:0] grid_height [CELLS];
    bit grid_known [CELLS];
    bit grid_valid [CELLS];
    bit grid_written [CELLS];
    logic [CFG_W-1:0] rows_reg = 7'd64;
    logic [CFG_W-1:0] cols_reg = 7'd64;

    out_item_t pending_results [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request = 1'b0;
    longint cycles = 0;
    int last_load = 0;

    // one directed row
    typedef struct {
        logic [CMD_W-1:0] cmd;
        int r;
        int c;
        int h;
        bit hk;
        bit typed;
        out_item_t want;
    } dir_row_t;

    function automatic int sat_dim(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    function automatic void relax(int from, int to, inout bit changed);
        if (!grid_valid[from]) return;
        if (!grid_valid[to] || grid_height[from] < grid_height[to]) begin
            grid_height[to] = grid_height[from];
            grid_valid[to] = 1'b1;
            changed = 1'b1;
        end
    endfunction

    // min-of-neighbours fill, repeated until stable; returns whether any cell in use is known
    function automatic bit fill_to_convergence();
        int nr, nc, i;
        bit changed, seen;
        nr = sat_dim(rows_reg);
        nc = sat_dim(cols_reg);
        for (int k = 0; k < CELLS; k++) grid_valid[k] = grid_known[k];
        do begin
            changed = 1'b0;
            seen = 1'b0;
            for (int c = 0; c < nc; c++) begin
                for (int r = 0; r < nr; r++) begin
                    i = r * NCOL + c;
                    if (grid_known[i]) begin
                        seen = 1'b1;
                        continue;
                    end
                    if (c > 0) relax(i - 1, i, changed);
                    if (c + 1 < nc) relax(i + 1, i, changed);
                    if (r > 0) relax(i - NCOL, i, changed);
                    if (r + 1 < nr) relax(i + NCOL, i, changed);
                end
            end
        end while (changed && seen);
        return seen;
    endfunction

    // applies one accepted item to the mirror; returns 1 with the answer if one is due
    function automatic bit predict_item(logic [CMD_W-1:0] cmd, int r, int c,
                                        logic signed [IO_H_W-1:0] h, bit hk,
                                        output out_item_t res);
        int i;
        i = r * NCOL + c;
        res = '0;
        case (cmd)
            CMD_LOAD: begin
                grid_height[i] = h;
                grid_known[i] = hk;
                grid_valid[i] = hk;
                grid_written[i] = 1'b1;
                return 1'b0;
            end
            CMD_FILL: begin
                res.kind = KIND_FILL;
                res.any = fill_to_convergence();
                return 1'b1;
            end
            CMD_READ: begin
                res.kind = KIND_READ;
                res.valid = grid_valid[i];
                res.height = grid_valid[i] ? grid_height[i] : '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // drive one item and wait for its handshake
    task automatic send_item(logic [CMD_W-1:0] cmd, int r, int c, int h, bit hk,
                             bit typed, out_item_t want);
        out_item_t res;
        bit due;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_row <= r[IDX_W-1:0];
        s_col <= c[IDX_W-1:0];
        s_height <= h[IO_H_W-1:0];
        s_height_known <= hk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due = predict_item(cmd, r, c, h[IO_H_W-1:0], hk, res);
        if (cmd == CMD_LOAD) last_load = r * NCOL + c;
        if (due) pending_results.push_back(typed ? want : res);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_ROWS) rows_reg = val;
        else cols_reg = val;
    endtask

    // let all results drain, then leave the block quiet for a while
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item kind=%0d", m_kind);
            end else begin
                want = pending_results.pop_front();
                if (m_kind !== want.kind || m_result_height !== want.height ||
                    m_result_valid !== want.valid || m_any_known !== want.any) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind=%0d h=%0d v=%0d any=%0d, got %0d %0d %0d %0d",
                                 want.kind, $signed(want.height), want.valid, want.any,
                                 m_kind, m_result_height, m_result_valid, m_any_known);
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(posedge aclk) begin
        int hold_left;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_rows [$];
        out_item_t none;
        logic [CFG_W-1:0] cfg_rows [8];
        logic [CFG_W-1:0] cfg_cols [8];
        int r, c, sel, nr, nc, i;
        logic [CMD_W-1:0] cmd;

        none = '0;
        cfg_rows = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd3, 7'd8, 7'd2, 7'd64};
        cfg_cols = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd5, 7'd2, 7'd64, 7'd64};
        for (int k = 0; k < CELLS; k++) begin
            grid_height[k] = '0;
            grid_known[k] = 1'b0;
            grid_valid[k] = 1'b0;
            grid_written[k] = 1'b0;
        end

        // directed rows: extremes, every command, ties, holes, repeated fill
        dir_rows = '{
            '{CMD_FILL, 0, 0, 0, 1'b0, 1'b1, '{KIND_FILL, 16'h0000, 1'b0, 1'b0}},
            '{CMD_LOAD, 0, 0, 32767, 1'b1, 1'b0, none},
            '{CMD_READ, 0, 0, 0, 1'b0, 1'b1, '{KIND_READ, 16'h7fff, 1'b1, 1'b0}},
            '{CMD_LOAD, 63, 63, -32768, 1'b1, 1'b0, none},
            '{CMD_READ, 63, 63, 0, 1'b0, 1'b1, '{KIND_READ, 16'h8000, 1'b1, 1'b0}},
            '{CMD_LOAD, 5, 5, -1, 1'b0, 1'b0, none},
            '{CMD_READ, 5, 5, 0, 1'b0, 1'b1, '{KIND_READ, 16'h0000, 1'b0, 1'b0}},
            '{CMD_NONE, 63, 0, -1, 1'b1, 1'b0, none},
            '{CMD_LOAD, 10, 10, 100, 1'b1, 1'b0, none},
            '{CMD_LOAD, 10, 12, 100, 1'b1, 1'b0, none},
            '{CMD_LOAD, 10, 11, 7, 1'b0, 1'b0, none},
            '{CMD_FILL, 0, 0, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 10, 11, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 5, 5, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 63, 0, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 0, 63, 0, 1'b0, 1'b0, none},
            '{CMD_LOAD, 0, 0, 0, 1'b0, 1'b0, none},
            '{CMD_LOAD, 63, 63, 5, 1'b0, 1'b0, none},
            '{CMD_FILL, 0, 0, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 0, 0, 0, 1'b0, 1'b0, none},
            '{CMD_READ, 10, 11, 0, 1'b0, 1'b0, none}
        };

        // reset and first settings
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(REG_ROWS, 7'd64);
        write_reg(REG_COLS, 7'd64);

        foreach (dir_rows[k])
            send_item(dir_rows[k].cmd, dir_rows[k].r, dir_rows[k].c, dir_rows[k].h,
                      dir_rows[k].hk, dir_rows[k].typed, dir_rows[k].want);
        drain();

        // random phases over several grid sizes and idling patterns
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_ROWS, cfg_rows[p]);
            write_reg(REG_COLS, cfg_cols[p]);
            send_idle_pct = (p < 3) ? 20 : (p < 6) ? 49 : 0;
            recv_idle_pct = (p < 3) ? 49 : (p < 6) ? 20 : 0;
            if (p == 4) hold_request = 1'b1;
            nr = sat_dim(rows_reg);
            nc = sat_dim(cols_reg);
            for (int n = 0; n < 125; n++) begin
                sel = $urandom_range(99);
                if ($urandom_range(9) == 0) begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                end else begin
                    r = $urandom_range(nr - 1);
                    c = $urandom_range(nc - 1);
                end
                if (sel < 2) cmd = CMD_NONE;
                else if (sel < 6 && !(nc == 64 && nr == 64 && n % 40 != 0)) cmd = CMD_FILL;
                else if (sel < 52) cmd = CMD_LOAD;
                else cmd = CMD_READ;
                if (cmd == CMD_READ) begin
                    i = r * NCOL + c;
                    if (!grid_written[i] && !grid_valid[i]) begin
                        r = last_load / NCOL;
                        c = last_load % NCOL;
                    end
                end
                send_item(cmd, r, c, $urandom_range(65535) - 32768,
                          $urandom_range(3) != 0, 1'b0, none);
            end
            send_item(CMD_FILL, 0, 0, 0, 1'b0, 1'b0, none);
            drain();
        end

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== grid_hole_fill_min_neighbour.f =====
rtl/core/ghf_pkg.sv
rtl/core/ghf_cell.sv
rtl/core/ghf_chain.sv
rtl/core/ghf_min_unit.sv
rtl/core/grid_hole_fill_min_neighbour.sv
bench/tb.sv
